// File: design/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// Shared constants and types for the cyclic code encoder and checker.
// ----------------------------------------------------------------------------
package cce_pkg;

    // stream word and register widths fixed by the interface
    localparam int WORD_W  = 7;
    localparam int TDATA_W = 8;
    localparam int GEN_W   = 8;

    // generator reset value, x^3 + x + 1
    localparam logic [GEN_W-1:0] GEN_RESET = 8'd11;

    // default code geometry
    localparam int CODE_LEN_DEF  = 7;
    localparam int MSG_LEN_DEF   = 4;
    localparam int CHECK_LEN_DEF = 3;

    // action codes carried in tuser
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // control travelling with each pipeline stage
    typedef struct packed {
        logic vld;
        logic action;
    } stage_ctl_t;

endpackage

// File: design/cce_div_stage.sv
// ----------------------------------------------------------------------------
// cce_div_stage
// One pipeline stage of the GF(2) long division: clears one bit of the
// working word by a conditional xor with the shifted generator.
// ----------------------------------------------------------------------------
module cce_div_stage #(
    parameter int CODE_LEN  = cce_pkg::CODE_LEN_DEF,
    parameter int CHECK_LEN = cce_pkg::CHECK_LEN_DEF,
    parameter int STEP_BIT  = cce_pkg::CODE_LEN_DEF - 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load_en,
    input  logic [CHECK_LEN-1:0]    gen_low,
    input  cce_pkg::stage_ctl_t     in_ctl,
    input  logic [CODE_LEN-1:0]     in_orig,
    input  logic [CODE_LEN-1:0]     in_work,
    output cce_pkg::stage_ctl_t     out_ctl,
    output logic [CODE_LEN-1:0]     out_orig,
    output logic [CODE_LEN-1:0]     out_work
);

    localparam int SHIFT = STEP_BIT - CHECK_LEN;

    logic [CHECK_LEN:0]   gen_full;
    logic [CODE_LEN-1:0]  gen_shift;
    logic [CODE_LEN-1:0]  work_next;

    cce_pkg::stage_ctl_t  ctl_reg;
    logic [CODE_LEN-1:0]  orig_reg;
    logic [CODE_LEN-1:0]  work_reg;

    // generator aligned so its leading term sits on the step bit
    always_comb begin
        gen_full  = {1'b1, gen_low};
        gen_shift = '0;
        for (int b = 0; b < CODE_LEN; b++) begin
            if (b >= SHIFT && b <= STEP_BIT) begin
                gen_shift[b] = gen_full[b - SHIFT];
            end
        end
    end

    // subtract the generator when the step bit is set
    always_comb begin
        if (in_work[STEP_BIT]) begin
            work_next = in_work ^ gen_shift;
        end else begin
            work_next = in_work;
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (load_en) begin
            ctl_reg <= in_ctl;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (load_en) begin
            orig_reg <= in_orig;
            work_reg <= work_next;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_orig = orig_reg;
    assign out_work = work_reg;

endmodule

// File: design/cyclic_code_encode_check.sv
// ----------------------------------------------------------------------------
// cyclic_code_encode_check
// Systematic binary cyclic code encoder and error detector with a
// programmable generator polynomial.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  tdata: word_in, tuser: action
//  m_       out        m_tvalid / m_tready  tdata: word_out, tuser: word_valid
//  cfg_     in         cfg_wr_en            cfg_wr_data: generator_poly
//
//  the pipeline is an input register, one stage per division step (one quotient
//  bit each), and an output register.
//  one item per cycle is sustained while m_ is not stalled; each stage holds one item.
//  reset clears all stage valids and loads the generator with x^3 + x + 1.
//  a stall on m_ backs up stage by stage; empty stages still fill, so
//  s_tready drops only when every stage holds an item.
//
module cyclic_code_encode_check #(
    parameter int CODE_LEN  = cce_pkg::CODE_LEN_DEF,
    parameter int MSG_LEN   = cce_pkg::MSG_LEN_DEF,
    parameter int CHECK_LEN = cce_pkg::CHECK_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cce_pkg::TDATA_W-1:0]   s_tdata,   // [6:0] word_in, [7] zero
    input  logic [0:0]                    s_tuser,   // [0] action
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cce_pkg::TDATA_W-1:0]   m_tdata,   // [6:0] word_out, [7] zero
    output logic [0:0]                    m_tuser,   // [0] word_valid
    // generator register write
    input  logic                          cfg_wr_en,
    input  logic [cce_pkg::GEN_W-1:0]     cfg_wr_data
);

    localparam int NSTEP  = CODE_LEN - CHECK_LEN;
    localparam int NSTAGE = NSTEP + 2;
    localparam int WW     = cce_pkg::WORD_W;

    logic [cce_pkg::GEN_W-1:0] gen_reg;

    cce_pkg::stage_ctl_t  ctl  [NSTEP+1];
    logic [CODE_LEN-1:0]  orig [NSTEP+1];
    logic [CODE_LEN-1:0]  work [NSTEP+1];

    logic [NSTAGE-1:0]    vld;
    logic [NSTAGE:0]      adv;

    cce_pkg::stage_ctl_t  in_ctl_next;
    logic [CODE_LEN-1:0]  in_word_next;
    cce_pkg::stage_ctl_t  in_ctl_reg;
    logic [CODE_LEN-1:0]  in_word_reg;

    logic [CHECK_LEN-1:0] rem;
    logic                 rem_zero;
    logic [WW-1:0]        enc_word;
    logic [WW-1:0]        dec_word;
    logic [WW-1:0]        out_data_next;
    logic                 out_flag_next;
    logic                 out_vld_reg;
    logic [WW-1:0]        out_data_reg;
    logic                 out_flag_reg;

    // generator register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= cce_pkg::GEN_RESET;
        end else if (cfg_wr_en) begin
            gen_reg <= cfg_wr_data;
        end
    end

    // per-stage advance: a stage loads when it is empty or its successor moves
    always_comb begin
        for (int k = 0; k <= NSTEP; k++) begin
            vld[k] = ctl[k].vld;
        end
        vld[NSTAGE-1] = out_vld_reg;
        adv[NSTAGE]   = m_tready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            adv[k] = !vld[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];

    // input word: message shifted up for encode, received word for decode
    always_comb begin
        in_ctl_next.vld    = s_tvalid;
        in_ctl_next.action = s_tuser[0];
        in_word_next       = '0;
        for (int b = 0; b < CODE_LEN; b++) begin
            if (s_tuser[0] == cce_pkg::ACT_DECODE) begin
                if (b < WW) begin
                    in_word_next[b] = s_tdata[b];
                end
            end else begin
                if (b >= CHECK_LEN && b - CHECK_LEN < MSG_LEN && b - CHECK_LEN < WW) begin
                    in_word_next[b] = s_tdata[b - CHECK_LEN];
                end
            end
        end
    end

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctl_reg <= '0;
        end else if (adv[0]) begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            in_word_reg <= in_word_next;
        end
    end

    assign ctl[0]  = in_ctl_reg;
    assign orig[0] = in_word_reg;
    assign work[0] = in_word_reg;

    // division stages, highest quotient bit first
    for (genvar j = 1; j <= NSTEP; j++) begin : g_step
        cce_div_stage #(
            .CODE_LEN  (CODE_LEN),
            .CHECK_LEN (CHECK_LEN),
            .STEP_BIT  (CODE_LEN - j)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load_en  (adv[j]),
            .gen_low  (gen_reg[CHECK_LEN-1:0]),
            .in_ctl   (ctl[j-1]),
            .in_orig  (orig[j-1]),
            .in_work  (work[j-1]),
            .out_ctl  (ctl[j]),
            .out_orig (orig[j]),
            .out_work (work[j])
        );
    end

    // result formatting from the remainder
    always_comb begin
        rem      = work[NSTEP][CHECK_LEN-1:0];
        rem_zero = (rem == '0);
        enc_word = '0;
        dec_word = '0;
        for (int b = 0; b < WW; b++) begin
            if (b < CODE_LEN) begin
                enc_word[b] = orig[NSTEP][b] ^ work[NSTEP][b];
            end
            if (b < MSG_LEN && b + CHECK_LEN < CODE_LEN) begin
                dec_word[b] = orig[NSTEP][b + CHECK_LEN];
            end
        end
        if (ctl[NSTEP].action == cce_pkg::ACT_DECODE) begin
            out_flag_next = rem_zero;
            out_data_next = rem_zero ? dec_word : '0;
        end else begin
            out_flag_next = 1'b1;
            out_data_next = enc_word;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv[NSTAGE-1]) begin
            out_vld_reg <= ctl[NSTEP].vld;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (adv[NSTAGE-1]) begin
            out_data_reg <= out_data_next;
            out_flag_reg <= out_flag_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(cce_pkg::TDATA_W - WW){1'b0}}, out_data_reg};
    assign m_tuser  = out_flag_reg;

endmodule

// File: design/cce_checker.sv
// ----------------------------------------------------------------------------
// cce_checker
// Port-level checks for the cyclic code encoder and checker, bound to the
// top level.
// ----------------------------------------------------------------------------
module cce_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [cce_pkg::TDATA_W-1:0]   s_tdata,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cce_pkg::TDATA_W-1:0]   m_tdata,
    input logic [0:0]                    m_tuser
);

    // a stalled result transfer holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a detected error always reports a zero word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == 1'b0) |-> (m_tdata == '0))
        else $error("error result with nonzero word");

    // input backpressure only when the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output free");

endmodule

bind cyclic_code_encode_check cce_checker u_cce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/cce_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cce_checker
// Watches the input, result and generator write ports of the cyclic code
// block, predicts each result from the accepted input and the generator in
// force, and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cce_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [cce_pkg::TDATA_W-1:0] s_tdata,   // [6:0] word_in, [7] zero
    input  logic [0:0]                  s_tuser,   // [0] action
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [cce_pkg::TDATA_W-1:0] m_tdata,   // [6:0] word_out, [7] zero
    input  logic [0:0]                  m_tuser,   // [0] word_valid
    input  logic                        cfg_wr_en,
    input  logic [cce_pkg::GEN_W-1:0]   cfg_wr_data,
    output int                          error_count,
    output int                          outstanding
);

    localparam int N  = cce_pkg::CODE_LEN_DEF;
    localparam int K  = cce_pkg::MSG_LEN_DEF;
    localparam int M  = cce_pkg::CHECK_LEN_DEF;
    localparam int WW = cce_pkg::WORD_W;
    localparam int GW = cce_pkg::GEN_W;

    typedef struct {
        logic [WW-1:0] word;
        logic          flag;
    } coder_out_t;

    coder_out_t        coder_out_q[$];
    logic [GW-1:0]     gen_reg;

    // remainder of a received or shifted word divided by g over GF(2)
    function automatic logic [M-1:0] gf2_mod(input logic [N-1:0] a_in,
                                             input logic [GW-1:0] gen);
        logic [N-1:0] a;
        logic [M:0]   g;
        a = a_in;
        g = {1'b1, gen[M-1:0]};
        for (int i = N - 1; i >= M; i--) begin
            if (a[i]) begin
                a = a ^ (N'(g) << (i - M));
            end
        end
        return a[M-1:0];
    endfunction

    // systematic encode, or syndrome check and message extraction
    function automatic coder_out_t coder_out(input logic act,
                                             input logic [WW-1:0] word,
                                             input logic [GW-1:0] gen);
        coder_out_t   r;
        logic [N-1:0] shifted;
        logic [N-1:0] rx;
        r.word = '0;
        r.flag = 1'b0;
        if (act == cce_pkg::ACT_ENCODE) begin
            // message bits above K drop out of the shift
            shifted = N'(word[K-1:0]) << M;
            r.word  = WW'(shifted ^ N'(gf2_mod(shifted, gen)));
            r.flag  = 1'b1;
        end else begin
            rx = word[N-1:0];
            if (gf2_mod(rx, gen) == '0) begin
                r.word = WW'(rx[N-1:M]);
                r.flag = 1'b1;
            end
        end
        return r;
    endfunction

    // track generator writes, predict on input transfers, compare on results
    always @(posedge aclk) begin : watch
        coder_out_t want;
        if (!aresetn) begin
            gen_reg     <= cce_pkg::GEN_RESET;
            coder_out_q.delete();
            error_count <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                gen_reg <= cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                if (coder_out_q.size() == 0) begin
                    if (error_count < 10) begin
                        $display("%0t: result transfer with none pending: word %h flag %b",
                                 $realtime, m_tdata[WW-1:0], m_tuser[0]);
                    end
                    error_count <= error_count + 1;
                end else begin
                    want = coder_out_q.pop_front();
                    if (m_tdata[WW-1:0] !== want.word || m_tuser[0] !== want.flag) begin
                        if (error_count < 10) begin
                            $display("%0t: mismatch: word exp %h got %h, flag exp %b got %b",
                                     $realtime, want.word, m_tdata[WW-1:0],
                                     want.flag, m_tuser[0]);
                        end
                        error_count <= error_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                coder_out_q.push_back(coder_out(s_tuser[0], s_tdata[WW-1:0], gen_reg));
            end
            outstanding <= coder_out_q.size();
        end
    end

endmodule

// File: tb/sv/tb_cyclic_code_encode_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cyclic_code_encode_check
// Drives encode and decode items through the cyclic code block under several
// generator settings and both directions of back-pressure; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_cyclic_code_encode_check;

    localparam int N          = cce_pkg::CODE_LEN_DEF;
    localparam int K          = cce_pkg::MSG_LEN_DEF;
    localparam int M          = cce_pkg::CHECK_LEN_DEF;
    localparam int WW         = cce_pkg::WORD_W;
    localparam int GW         = cce_pkg::GEN_W;
    localparam int LATENCY    = N - M + 2;
    localparam int STALL_MAX  = 2000;
    localparam int PHASE_LEN  = 230;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [cce_pkg::TDATA_W-1:0]   s_tdata     = '0;
    logic [0:0]                    s_tuser     = '0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [cce_pkg::TDATA_W-1:0]   m_tdata;
    logic [0:0]                    m_tuser;
    logic                          cfg_wr_en   = 1'b0;
    logic [GW-1:0]                 cfg_wr_data = '0;

    int                   error_count;
    int                   outstanding;
    int                   tx_idle_pct  = 12;
    int                   rx_stall_pct = 71;
    int                   stall_cycles = 0;
    logic [GW-1:0]        gen_now      = cce_pkg::GEN_RESET;

    cyclic_code_encode_check uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    tb_cce_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // 2 ns clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // a valid codeword: message times g, any multiple of g passes the check
    function automatic logic [WW-1:0] times_generator(input logic [K-1:0] msg,
                                                      input logic [GW-1:0] gen);
        logic [WW-1:0] prod;
        logic [M:0]    g;
        prod = '0;
        g    = {1'b1, gen[M-1:0]};
        for (int i = 0; i < K; i++) begin
            if (msg[i]) begin
                prod = prod ^ (WW'(g) << i);
            end
        end
        return prod;
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic act, input logic [WW-1:0] word);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, word};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drain the block, then write the generator
    task automatic load_generator(input logic [GW-1:0] val);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        gen_now     = val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random mix: raw encodes, clean codewords, corrupted codewords, noise
    task automatic send_random_item();
        int            pick;
        logic [WW-1:0] cw;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_item(cce_pkg::ACT_ENCODE, WW'($urandom_range(0, 127)));
        end else begin
            cw   = times_generator(K'($urandom_range(0, 15)), gen_now);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_item(cce_pkg::ACT_DECODE, cw);
            end else if (pick < 85) begin
                cw = cw ^ (WW'(1) << $urandom_range(0, N - 1));
                if ($urandom_range(0, 2) == 0) begin
                    cw = cw ^ (WW'(1) << $urandom_range(0, N - 1));
                end
                send_item(cce_pkg::ACT_DECODE, cw);
            end else begin
                send_item(cce_pkg::ACT_DECODE, WW'($urandom_range(0, 127)));
            end
        end
    endtask

    initial begin
        logic [GW-1:0] phase_gen [6];
        phase_gen[0] = 8'd1;
        phase_gen[1] = 8'd255;
        phase_gen[2] = GW'($urandom_range(1, 255));
        phase_gen[3] = cce_pkg::GEN_RESET;
        phase_gen[4] = GW'($urandom_range(1, 255));
        phase_gen[5] = GW'($urandom_range(1, 255));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset generator x^3 + x + 1: field extremes, excess message bits
        send_item(cce_pkg::ACT_ENCODE, 7'd0);
        send_item(cce_pkg::ACT_ENCODE, 7'd15);
        send_item(cce_pkg::ACT_ENCODE, 7'd127);
        send_item(cce_pkg::ACT_ENCODE, 7'd5);
        send_item(cce_pkg::ACT_DECODE, 7'd0);
        send_item(cce_pkg::ACT_DECODE, 7'd127);
        send_item(cce_pkg::ACT_DECODE, times_generator(4'd11, gen_now));
        send_item(cce_pkg::ACT_DECODE, times_generator(4'd11, gen_now) ^ 7'h40);
        send_item(cce_pkg::ACT_DECODE, 7'd1);

        // register bits above the degree are ignored
        load_generator(8'd255);
        send_item(cce_pkg::ACT_ENCODE, 7'd15);
        send_item(cce_pkg::ACT_ENCODE, 7'd9);
        send_item(cce_pkg::ACT_DECODE, 7'd127);
        send_item(cce_pkg::ACT_DECODE, times_generator(4'd6, gen_now));
        send_item(cce_pkg::ACT_DECODE, 7'd64);

        // only the leading coefficient set: g = x^3
        load_generator(8'd8);
        send_item(cce_pkg::ACT_ENCODE, 7'd15);
        send_item(cce_pkg::ACT_DECODE, 7'b1111000);
        send_item(cce_pkg::ACT_DECODE, 7'b1111001);

        // random phases across generators and idle patterns
        for (int p = 0; p < 6; p++) begin
            load_generator(phase_gen[p]);
            if (p < 2) begin
                tx_idle_pct  = 12;
                rx_stall_pct = 71;
            end else if (p < 4) begin
                tx_idle_pct  = 71;
                rx_stall_pct = 12;
            end else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            for (int i = 0; i < PHASE_LEN; i++) begin
                send_random_item();
            end
        end
        s_tvalid <= 1'b0;

        // drain and settle
        while (outstanding != 0) @(posedge aclk);
        repeat (LATENCY * 4) @(posedge aclk);
        if (error_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
